[sv/apch_pkg.sv]
// Package for the four-axis pulse command and homing unit.
// Holds the request and result types, function and status codes and the homing speeds.
// No dependencies.
`timescale 1ns / 1ps

package apch_pkg;

    localparam int AXIS_COUNT  = 4;
    localparam int STAGE_W     = $clog2(AXIS_COUNT + 1);
    localparam int AXIS_W      = $clog2(AXIS_COUNT);
    localparam int DELTA_W     = 8;
    localparam int LIMIT_W     = 7;
    localparam int POS_W       = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    localparam logic [STAGE_W-1:0] STAGE_DONE = STAGE_W'(AXIS_COUNT);
    localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(AXIS_COUNT - 1);

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [LIMIT_W-1:0] limit_t;

    localparam delta_t HOME_SPEED [AXIS_COUNT] = '{8'sd4, 8'sd5, 8'sd8, 8'sd30};
    localparam logic [AXIS_COUNT-1:0] HOME_NEGATE = 4'b0101;
    localparam limit_t LIMIT_RESET = 7'd127;

    typedef enum logic [1:0] {
        FUNC_PULSE      = 2'd0,
        FUNC_SCAN_STEP  = 2'd1,
        FUNC_SCAN_RESET = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_WRITTEN = 2'd1,
        STATUS_REJECT  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POLARITY = 3'd0,
        CFG_LIMIT0   = 3'd1,
        CFG_LIMIT1   = 3'd2,
        CFG_LIMIT2   = 3'd3,
        CFG_LIMIT3   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]           func;
        delta_t               delta_axis0;
        delta_t               delta_axis1;
        delta_t               delta_axis2;
        delta_t               delta_axis3;
        logic [3:0]           switch_bits;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [7:0]               drive_byte0;
        logic [7:0]               drive_byte1;
        logic [7:0]               drive_byte2;
        logic [7:0]               drive_byte3;
        logic                     scan_done;
        logic                     capture_enable;
        logic signed [POS_W-1:0]  position_axis0;
        logic signed [POS_W-1:0]  position_axis1;
        logic signed [POS_W-1:0]  position_axis2;
        logic signed [POS_W-1:0]  position_axis3;
    } res_t;

    function automatic delta_t home_drive(input logic [AXIS_W-1:0] axis);
        delta_t speed;
        speed = HOME_SPEED[axis];
        return HOME_NEGATE[axis] ? -speed : speed;
    endfunction

endpackage

[sv/axis_pulse_command_and_homing_top.sv]
// Channel     Direction  Handshake              Payload
// s_          in         s_valid / s_ready      s_data   (req_t)
// m_          out        m_valid / m_ready      m_data   (res_t)
// cfg_        in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request waits in the input register while the drive bytes and totals are
// computed into the result register.
// A new request is taken every cycle while the result side keeps up; the
// result register sets the rate at one request per cycle.
// Reset is synchronous on aresetn low and clears the stage, capture level, totals and
// polarity; limits go to 127. A stalled result holds both stages; cfg_ready is always high.
//
// Top level of the pulse command and homing unit; depends on apch_pkg.
`timescale 1ns / 1ps

module axis_pulse_command_and_homing_top
    import apch_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  req_t                   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output res_t                   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                    in_valid_reg;
    req_t                    in_req_reg;
    logic                    out_valid_reg;
    res_t                    out_res_reg;
    res_t                    out_res_next;
    logic                    out_free;
    logic                    step_fire;

    logic [AXIS_COUNT-1:0]   polarity_reg;
    limit_t                  limit_reg [AXIS_COUNT];
    logic [STAGE_W-1:0]      stage_reg;
    logic [STAGE_W-1:0]      stage_next;
    logic                    capture_reg;
    logic                    capture_next;
    logic [POS_W-1:0]        totals_reg [AXIS_COUNT];
    logic [POS_W-1:0]        totals_next [AXIS_COUNT];

    delta_t                  delta [AXIS_COUNT];
    logic [DELTA_W-1:0]      mag [AXIS_COUNT];
    logic [AXIS_COUNT-1:0]   dir;
    logic [AXIS_COUNT-1:0]   over;
    logic [7:0]              bytes [AXIS_COUNT];
    logic                    issue;
    logic                    done;
    status_t                 status;
    logic [AXIS_W-1:0]       axis;

    assign out_free  = !out_valid_reg || m_ready;
    assign step_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_res_reg;
    assign axis      = AXIS_W'(STAGE_LAST - stage_reg);

    always_comb begin
        for (int i = 0; i < AXIS_COUNT; i++) begin
            delta[i] = '0;
        end
        issue        = 1'b0;
        done         = 1'b0;
        stage_next   = stage_reg;
        capture_next = capture_reg;
        unique case (in_req_reg.func)
            FUNC_PULSE: begin
                delta[0] = in_req_reg.delta_axis0;
                delta[1] = in_req_reg.delta_axis1;
                delta[2] = in_req_reg.delta_axis2;
                delta[3] = in_req_reg.delta_axis3;
                issue    = 1'b1;
            end
            FUNC_SCAN_STEP: begin
                if (stage_reg < STAGE_DONE) begin
                    if (!in_req_reg.switch_bits[axis]) begin
                        delta[axis] = home_drive(axis);
                        issue       = 1'b1;
                    end else begin
                        stage_next = stage_reg + STAGE_W'(1);
                    end
                end else begin
                    capture_next = 1'b1;
                    issue        = 1'b1;
                    done         = 1'b1;
                end
            end
            FUNC_SCAN_RESET: begin
                stage_next   = '0;
                capture_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < AXIS_COUNT; i++) begin
            mag[i]  = delta[i][DELTA_W-1] ? DELTA_W'(-delta[i]) : DELTA_W'(delta[i]);
            dir[i]  = polarity_reg[i] ^ delta[i][DELTA_W-1];
            over[i] = mag[i] > {1'b0, limit_reg[i]};
        end
        status = STATUS_NONE;
        for (int i = 0; i < AXIS_COUNT; i++) begin
            bytes[i]       = '0;
            totals_next[i] = totals_reg[i];
        end
        if (issue) begin
            if (|over) begin
                status = STATUS_REJECT;
            end else begin
                status = STATUS_WRITTEN;
                for (int i = 0; i < AXIS_COUNT; i++) begin
                    bytes[i]       = {dir[i], mag[i][LIMIT_W-1:0]};
                    totals_next[i] = totals_reg[i] + POS_W'(signed'(delta[i]));
                end
            end
        end
        out_res_next.status         = status;
        out_res_next.drive_byte0    = bytes[0];
        out_res_next.drive_byte1    = bytes[1];
        out_res_next.drive_byte2    = bytes[2];
        out_res_next.drive_byte3    = bytes[3];
        out_res_next.scan_done      = done;
        out_res_next.capture_enable = capture_next;
        out_res_next.position_axis0 = totals_next[0];
        out_res_next.position_axis1 = totals_next[1];
        out_res_next.position_axis2 = totals_next[2];
        out_res_next.position_axis3 = totals_next[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stage_reg     <= '0;
            capture_reg   <= 1'b0;
            polarity_reg  <= '0;
            for (int i = 0; i < AXIS_COUNT; i++) begin
                limit_reg[i]  <= LIMIT_RESET;
                totals_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire) begin
                stage_reg   <= stage_next;
                capture_reg <= capture_next;
                for (int i = 0; i < AXIS_COUNT; i++) begin
                    totals_reg[i] <= totals_next[i];
                end
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_POLARITY: polarity_reg <= cfg_data[AXIS_COUNT-1:0];
                    CFG_LIMIT0:   limit_reg[0] <= cfg_data[LIMIT_W-1:0];
                    CFG_LIMIT1:   limit_reg[1] <= cfg_data[LIMIT_W-1:0];
                    CFG_LIMIT2:   limit_reg[2] <= cfg_data[LIMIT_W-1:0];
                    CFG_LIMIT3:   limit_reg[3] <= cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_data;
        end
        if (step_fire) begin
            out_res_reg <= out_res_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg <= STAGE_DONE)
        else $error("homing stage beyond last axis");

    a_reject_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_REJECT) |->
        (m_data.drive_byte0 == '0 && m_data.drive_byte1 == '0 &&
         m_data.drive_byte2 == '0 && m_data.drive_byte3 == '0))
        else $error("rejected request issued drive bytes");

    a_done_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.scan_done) |->
        (m_data.capture_enable && m_data.status == STATUS_WRITTEN))
        else $error("scan done without capture enable and written bytes");

    a_reject_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && status != STATUS_WRITTEN) |=>
        (totals_reg[0] == $past(totals_reg[0]) && totals_reg[3] == $past(totals_reg[3])))
        else $error("totals moved without written pulses");
`endif

endmodule
